// ----- hw/rtl/gdas_pkg.sv -----
package gdas_pkg;

  // Field widths
  localparam int OP_W    = 2;
  localparam int DAY_W   = 5;
  localparam int MON_W   = 4;
  localparam int YEAR_W  = 14;
  localparam int CNT_W   = 16;

  // Working year carries one extra bit so a carry past the top year is visible
  localparam int WYEAR_W = YEAR_W + 1;

  localparam int YEAR_MAX   = 9999;
  localparam int YEAR_RESET = 1970;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 2'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 2'd2;

  // Month codes
  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  // year / 100 by reciprocal: exact for every year below 25600 (8-bit quotient)
  localparam int Q_MUL  = 5243;
  localparam int Q_SHIFT = 19;
  localparam int Q_MUL_W = 13;
  localparam int PROD_W = WYEAR_W + Q_MUL_W;
  localparam int QUO_W  = 8;

  // Microprogram
  localparam int UPC_W = 5;

  typedef enum logic [3:0] {
    U_NOP,
    U_LDSEL,   // working date <= load fields
    U_QUO,     // quotient of year by 100
    U_LEN,     // month length of working month/year
    U_FADD,    // day += remaining count
    U_FSTEP,   // jump to first of next month
    U_BSUB,    // day -= remaining count
    U_BSTEP,   // drop back into previous month
    U_BSETD,   // day <= month length
    U_COMMIT,  // held date <= working date
    U_FAIL     // reject, held date untouched
  } uop_t;

  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_OP_LOAD,
    C_OP_ADD,
    C_OP_SUB,
    C_LOAD_BAD,
    C_DAY_GT_LEN,
    C_FWD_FIT,
    C_YEAR_OK,
    C_BWD_FIT,
    C_YEAR_ZERO
  } cond_t;

  typedef struct packed {
    uop_t             uop;
    cond_t            cond;
    logic [UPC_W-1:0] target;
    logic             done;
  } ctl_t;

  // Datapath flags seen by the branch logic
  typedef struct packed {
    logic op_load;
    logic op_add;
    logic op_sub;
    logic load_bad;
    logic day_gt_len;
    logic fwd_fit;
    logic year_ok;
    logic bwd_fit;
    logic year_zero;
  } stat_t;

  // Sequencer strobes to the datapath
  typedef struct packed {
    logic start;
    logic step_en;
  } seqc_t;

  // Step addresses
  localparam logic [UPC_W-1:0] A_DISP  = 5'd0;
  localparam logic [UPC_W-1:0] A_BADOP = 5'd3;
  localparam logic [UPC_W-1:0] A_LOAD  = 5'd4;
  localparam logic [UPC_W-1:0] A_FWD   = 5'd9;
  localparam logic [UPC_W-1:0] A_FAIL  = 5'd14;
  localparam logic [UPC_W-1:0] A_FEND  = 5'd15;
  localparam logic [UPC_W-1:0] A_BWD   = 5'd17;
  localparam logic [UPC_W-1:0] A_BEND  = 5'd23;

  function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      MON_FEB: len = leap ? DAY_W'(29) : DAY_W'(28);
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = DAY_W'(30);
      default: len = DAY_W'(31);
    endcase
    return len;
  endfunction

endpackage

// ----- hw/rtl/gdas_if.sv -----
interface gdas_in_if;
  import gdas_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [DAY_W-1:0]    load_day;
  logic [MON_W-1:0]    load_month;
  logic [YEAR_W-1:0]   load_year;
  logic [CNT_W-1:0]    day_count;

  modport source(output valid, op, load_day, load_month, load_year, day_count,
                 input ready);
  modport sink(input valid, op, load_day, load_month, load_year, day_count,
               output ready);
endinterface

interface gdas_out_if;
  import gdas_pkg::*;
  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    out_day;
  logic [MON_W-1:0]    out_month;
  logic [YEAR_W-1:0]   out_year;
  logic                error;

  modport source(output valid, out_day, out_month, out_year, error,
                 input ready);
  modport sink(input valid, out_day, out_month, out_year, error,
               output ready);
endinterface

// ----- hw/rtl/gdas_urom.sv -----
module gdas_urom (
  input  logic [gdas_pkg::UPC_W-1:0] upc,
  output gdas_pkg::ctl_t             ctl
);
  import gdas_pkg::*;

  // Control store: {uop, cond, target, done}
  always_comb begin
    case (upc)
      // dispatch on op code; op 3 falls into a reject
      5'd0:  ctl = '{U_NOP,    C_OP_LOAD,    A_LOAD,  1'b0};
      5'd1:  ctl = '{U_NOP,    C_OP_ADD,     A_FWD,   1'b0};
      5'd2:  ctl = '{U_NOP,    C_OP_SUB,     A_BWD,   1'b0};
      5'd3:  ctl = '{U_FAIL,   C_NEVER,      A_DISP,  1'b1};
      // load and validate
      5'd4:  ctl = '{U_LDSEL,  C_NEVER,      A_DISP,  1'b0};
      5'd5:  ctl = '{U_QUO,    C_LOAD_BAD,   A_FAIL,  1'b0};
      5'd6:  ctl = '{U_LEN,    C_NEVER,      A_DISP,  1'b0};
      5'd7:  ctl = '{U_NOP,    C_DAY_GT_LEN, A_FAIL,  1'b0};
      5'd8:  ctl = '{U_COMMIT, C_NEVER,      A_DISP,  1'b1};
      // forward walk, one month per pass
      5'd9:  ctl = '{U_QUO,    C_NEVER,      A_DISP,  1'b0};
      5'd10: ctl = '{U_LEN,    C_NEVER,      A_DISP,  1'b0};
      5'd11: ctl = '{U_NOP,    C_FWD_FIT,    A_FEND,  1'b0};
      5'd12: ctl = '{U_FSTEP,  C_NEVER,      A_DISP,  1'b0};
      5'd13: ctl = '{U_NOP,    C_YEAR_OK,    A_FWD,   1'b0};
      5'd14: ctl = '{U_FAIL,   C_NEVER,      A_DISP,  1'b1};
      5'd15: ctl = '{U_FADD,   C_NEVER,      A_DISP,  1'b0};
      5'd16: ctl = '{U_COMMIT, C_NEVER,      A_DISP,  1'b1};
      // backward walk, one month per pass
      5'd17: ctl = '{U_NOP,    C_BWD_FIT,    A_BEND,  1'b0};
      5'd18: ctl = '{U_BSTEP,  C_NEVER,      A_DISP,  1'b0};
      5'd19: ctl = '{U_NOP,    C_YEAR_ZERO,  A_FAIL,  1'b0};
      5'd20: ctl = '{U_QUO,    C_NEVER,      A_DISP,  1'b0};
      5'd21: ctl = '{U_LEN,    C_NEVER,      A_DISP,  1'b0};
      5'd22: ctl = '{U_BSETD,  C_ALWAYS,     A_BWD,   1'b0};
      5'd23: ctl = '{U_BSUB,   C_NEVER,      A_DISP,  1'b0};
      5'd24: ctl = '{U_COMMIT, C_NEVER,      A_DISP,  1'b1};
      default: ctl = '{U_FAIL, C_NEVER,      A_DISP,  1'b1};
    endcase
  end

endmodule

// ----- hw/rtl/gdas_seq.sv -----
module gdas_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  gdas_pkg::ctl_t             ctl,
  input  gdas_pkg::stat_t            stat,
  output logic [gdas_pkg::UPC_W-1:0] upc,
  output gdas_pkg::seqc_t            seqc
);
  import gdas_pkg::*;

  typedef enum logic {S_IDLE, S_RUN} state_t;

  state_t           state_r;
  logic [UPC_W-1:0] upc_r;
  logic             out_valid_r;
  logic             take;
  logic             stall;

  // branch condition
  always_comb begin
    case (ctl.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_OP_LOAD:    take = stat.op_load;
      C_OP_ADD:     take = stat.op_add;
      C_OP_SUB:     take = stat.op_sub;
      C_LOAD_BAD:   take = stat.load_bad;
      C_DAY_GT_LEN: take = stat.day_gt_len;
      C_FWD_FIT:    take = stat.fwd_fit;
      C_YEAR_OK:    take = stat.year_ok;
      C_BWD_FIT:    take = stat.bwd_fit;
      C_YEAR_ZERO:  take = stat.year_zero;
      default:      take = 1'b0;
    endcase
  end

  // final step waits while the output word is still unclaimed
  assign stall        = ctl.done && out_valid_r && !out_ready;
  assign in_ready     = (state_r == S_IDLE);
  assign seqc.start   = in_valid && in_ready;
  assign seqc.step_en = (state_r == S_RUN) && !stall;
  assign out_valid    = out_valid_r;
  assign upc          = upc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      upc_r       <= A_DISP;
      out_valid_r <= 1'b0;
    end else begin
      // a new word on the final step wins over the claim of the old one
      if (seqc.step_en && ctl.done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (seqc.start) begin
            state_r <= S_RUN;
            upc_r   <= A_DISP;
          end
        end
        S_RUN: begin
          if (seqc.step_en) begin
            if (ctl.done) begin
              state_r <= S_IDLE;
            end else if (take) begin
              upc_r <= ctl.target;
            end else begin
              upc_r <= upc_r + UPC_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/gdas_dp.sv -----
module gdas_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  gdas_pkg::seqc_t             seqc,
  input  gdas_pkg::ctl_t              ctl,
  input  logic [gdas_pkg::OP_W-1:0]   in_op,
  input  logic [gdas_pkg::DAY_W-1:0]  in_load_day,
  input  logic [gdas_pkg::MON_W-1:0]  in_load_month,
  input  logic [gdas_pkg::YEAR_W-1:0] in_load_year,
  input  logic [gdas_pkg::CNT_W-1:0]  in_day_count,
  output gdas_pkg::stat_t             stat,
  output logic [gdas_pkg::DAY_W-1:0]  out_day,
  output logic [gdas_pkg::MON_W-1:0]  out_month,
  output logic [gdas_pkg::YEAR_W-1:0] out_year,
  output logic                        out_error
);
  import gdas_pkg::*;

  // held date
  logic [DAY_W-1:0]   cur_day_r;
  logic [MON_W-1:0]   cur_month_r;
  logic [YEAR_W-1:0]  cur_year_r;

  // item latches and working registers
  logic [OP_W-1:0]    op_r;
  logic [DAY_W-1:0]   ld_day_r;
  logic [MON_W-1:0]   ld_month_r;
  logic [YEAR_W-1:0]  ld_year_r;
  logic [DAY_W-1:0]   d_r;
  logic [MON_W-1:0]   m_r;
  logic [WYEAR_W-1:0] y_r;
  logic [CNT_W-1:0]   rem_r;
  logic [QUO_W-1:0]   q_r;
  logic [DAY_W-1:0]   len_r;

  // output word
  logic [DAY_W-1:0]   out_day_r;
  logic [MON_W-1:0]   out_month_r;
  logic [YEAR_W-1:0]  out_year_r;
  logic               out_error_r;

  logic [PROD_W-1:0]  prod;
  logic               div100;
  logic               leap;
  logic               exec;

  assign exec = seqc.step_en;

  // year / 100 and the leap rule
  assign prod   = PROD_W'(y_r) * PROD_W'(Q_MUL);
  assign div100 = ((WYEAR_W'(q_r) * WYEAR_W'(100)) == y_r);
  assign leap   = (y_r[1:0] == 2'b00) && (!div100 || (q_r[1:0] == 2'b00));

  // branch flags
  assign stat.op_load    = (op_r == OP_LOAD);
  assign stat.op_add     = (op_r == OP_ADD);
  assign stat.op_sub     = (op_r == OP_SUB);
  assign stat.load_bad   = (m_r == '0) || (m_r > MON_DEC) || (y_r == '0) ||
                           (y_r > WYEAR_W'(YEAR_MAX)) || (d_r == '0);
  assign stat.day_gt_len = (d_r > len_r);
  assign stat.fwd_fit    = ((17'(d_r) + 17'(rem_r)) <= 17'(len_r));
  assign stat.year_ok    = (y_r <= WYEAR_W'(YEAR_MAX));
  assign stat.bwd_fit    = (rem_r < CNT_W'(d_r));
  assign stat.year_zero  = (y_r == '0);

  // working registers
  always_ff @(posedge clk) begin
    if (seqc.start) begin
      op_r       <= in_op;
      ld_day_r   <= in_load_day;
      ld_month_r <= in_load_month;
      ld_year_r  <= in_load_year;
      rem_r      <= in_day_count;
      d_r        <= cur_day_r;
      m_r        <= cur_month_r;
      y_r        <= WYEAR_W'(cur_year_r);
    end else if (exec) begin
      case (ctl.uop)
        U_LDSEL: begin
          d_r <= ld_day_r;
          m_r <= ld_month_r;
          y_r <= WYEAR_W'(ld_year_r);
        end
        U_QUO:   q_r   <= prod[Q_SHIFT +: QUO_W];
        U_LEN:   len_r <= month_len(m_r, leap);
        U_FADD:  d_r   <= d_r + rem_r[DAY_W-1:0];
        U_FSTEP: begin
          rem_r <= rem_r - (CNT_W'(len_r) + CNT_W'(1) - CNT_W'(d_r));
          d_r   <= DAY_W'(1);
          if (m_r == MON_DEC) begin
            m_r <= MON_JAN;
            y_r <= y_r + WYEAR_W'(1);
          end else begin
            m_r <= m_r + MON_W'(1);
          end
        end
        U_BSUB:  d_r <= d_r - rem_r[DAY_W-1:0];
        U_BSTEP: begin
          rem_r <= rem_r - CNT_W'(d_r);
          if (m_r == MON_JAN) begin
            m_r <= MON_DEC;
            y_r <= y_r - WYEAR_W'(1);
          end else begin
            m_r <= m_r - MON_W'(1);
          end
        end
        U_BSETD: d_r <= len_r;
        default: ;
      endcase
    end
  end

  // held date, updated only by a commit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_day_r   <= DAY_W'(1);
      cur_month_r <= MON_JAN;
      cur_year_r  <= YEAR_W'(YEAR_RESET);
    end else if (exec && (ctl.uop == U_COMMIT)) begin
      cur_day_r   <= d_r;
      cur_month_r <= m_r;
      cur_year_r  <= y_r[YEAR_W-1:0];
    end
  end

  // output word, loaded on the final step
  always_ff @(posedge clk) begin
    if (exec && ctl.done) begin
      if (ctl.uop == U_COMMIT) begin
        out_day_r   <= d_r;
        out_month_r <= m_r;
        out_year_r  <= y_r[YEAR_W-1:0];
        out_error_r <= 1'b0;
      end else begin
        out_day_r   <= cur_day_r;
        out_month_r <= cur_month_r;
        out_year_r  <= cur_year_r;
        out_error_r <= 1'b1;
      end
    end
  end

  assign out_day   = out_day_r;
  assign out_month = out_month_r;
  assign out_year  = out_year_r;
  assign out_error = out_error_r;

endmodule

// ----- hw/rtl/gregorian_date_add_subtract_days.sv -----
// A load is validated and committed by the load steps of the microprogram; add
// and subtract walk one month per pass of their loop, so their run time grows
// with the months crossed. The month walk in the microcoded sequencer sets it.
// One word in flight; the next is taken the cycle after the
// result is written to the output register.
// Reset (synchronous, rst_n low): date 1/1/1970, sequencer idle, no output.
module gregorian_date_add_subtract_days (
  input  logic        clk,
  input  logic        rst_n,
  gdas_in_if.sink     in_ch,
  gdas_out_if.source  out_ch
);
  import gdas_pkg::*;

  logic [UPC_W-1:0] upc;
  ctl_t             ctl;
  stat_t            stat;
  seqc_t            seqc;

  gdas_urom u_urom (
    .upc (upc),
    .ctl (ctl)
  );

  gdas_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .ctl       (ctl),
    .stat      (stat),
    .upc       (upc),
    .seqc      (seqc)
  );

  gdas_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .seqc          (seqc),
    .ctl           (ctl),
    .in_op         (in_ch.op),
    .in_load_day   (in_ch.load_day),
    .in_load_month (in_ch.load_month),
    .in_load_year  (in_ch.load_year),
    .in_day_count  (in_ch.day_count),
    .stat          (stat),
    .out_day       (out_ch.out_day),
    .out_month     (out_ch.out_month),
    .out_year      (out_ch.out_year),
    .out_error     (out_ch.error)
  );

endmodule

// ----- hw/rtl/gdas_checker.sv -----
module gdas_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gdas_pkg::DAY_W-1:0]  out_day,
  input logic [gdas_pkg::MON_W-1:0]  out_month,
  input logic [gdas_pkg::YEAR_W-1:0] out_year,
  input logic                        error
);
  import gdas_pkg::*;

  // one word at a time: a taken word closes the input
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while a word is in flight");

  // reported date always has day, month and year in range
  a_date_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_day != '0) && (out_month != '0) && (out_month <= MON_DEC) &&
                  (out_year != '0) && (out_year <= YEAR_W'(YEAR_MAX)))
    else $error("result date out of range");

  // February never reports beyond day 29
  a_feb_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_month == MON_FEB)) |-> (out_day <= DAY_W'(29)))
    else $error("February day beyond 29");

  // a waiting result holds its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_day) && $stable(out_month) &&
       $stable(out_year) && $stable(error)))
    else $error("output word dropped or changed while stalled");

endmodule

bind gregorian_date_add_subtract_days gdas_checker u_gdas_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_day   (out_ch.out_day),
  .out_month (out_ch.out_month),
  .out_year  (out_ch.out_year),
  .error     (out_ch.error)
);

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gdas_pkg::*;

  // op code the block must reject
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int WORDS_PER_PHASE = 62;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    logic [DAY_W-1:0]  day;
    logic [MON_W-1:0]  month;
    logic [YEAR_W-1:0] year;
    logic              err;
  } date_word_t;

  // Tracks the held date and the result words still owed by the block
  class date_scoreboard;
    int unsigned held_day;
    int unsigned held_month;
    int unsigned held_year;
    date_word_t  pending_dates[$];
    int          mismatches;

    function new();
      held_day   = 1;
      held_month = MON_JAN;
      held_year  = YEAR_RESET;
      mismatches = 0;
    endfunction

    function bit is_leap(int unsigned y);
      return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
    endfunction

    function int unsigned days_in(int unsigned m, int unsigned y);
      int unsigned n;
      case (m)
        MON_FEB: n = is_leap(y) ? 29 : 28;
        MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 30;
        default: n = 31;
      endcase
      return n;
    endfunction

    // Apply one accepted word to the held date and queue the expected result
    function void note_word(logic [OP_W-1:0] op, logic [DAY_W-1:0] ld,
                            logic [MON_W-1:0] lm, logic [YEAR_W-1:0] ly,
                            logic [CNT_W-1:0] cnt);
      int unsigned d, m, y, rem, len;
      bit ok, walking;
      date_word_t w;
      d = held_day;
      m = held_month;
      y = held_year;
      ok = 0;
      rem = cnt;
      walking = 1;
      case (op)
        OP_LOAD: begin
          ok = (lm >= MON_JAN) && (lm <= MON_DEC) && (ly >= 1) && (ly <= YEAR_MAX) &&
               (ld >= 1) && (ld <= days_in(lm, ly));
          d = ld;
          m = lm;
          y = ly;
        end
        OP_ADD: begin
          ok = 1;
          while (walking) begin
            len = days_in(m, y);
            if (d + rem <= len) begin
              d += rem;
              walking = 0;
            end else begin
              rem -= len + 1 - d;
              d = 1;
              m++;
              if (m > MON_DEC) begin
                m = MON_JAN;
                y++;
                if (y > YEAR_MAX) begin
                  ok = 0;
                  walking = 0;
                end
              end
            end
          end
        end
        OP_SUB: begin
          ok = 1;
          while (walking) begin
            if (rem < d) begin
              d -= rem;
              walking = 0;
            end else begin
              rem -= d;
              m--;
              if (m == 0) begin
                m = MON_DEC;
                if (y <= 1) begin
                  ok = 0;
                  walking = 0;
                end else begin
                  y--;
                end
              end
              if (walking) d = days_in(m, y);
            end
          end
        end
        default: ok = 0;
      endcase
      if (ok) begin
        held_day   = d;
        held_month = m;
        held_year  = y;
      end
      w.day   = held_day[DAY_W-1:0];
      w.month = held_month[MON_W-1:0];
      w.year  = held_year[YEAR_W-1:0];
      w.err   = !ok;
      pending_dates.push_back(w);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_word(logic [DAY_W-1:0] day, logic [MON_W-1:0] month,
                             logic [YEAR_W-1:0] year, logic err);
      date_word_t w;
      if (pending_dates.size() == 0) begin
        $error("result word with nothing expected: %0d/%0d/%0d err %0b",
               day, month, year, err);
        mismatches++;
        return;
      end
      w = pending_dates.pop_front();
      if (day !== w.day) begin
        $error("out_day: expected %0d, got %0d", w.day, day);
        mismatches++;
      end
      if (month !== w.month) begin
        $error("out_month: expected %0d, got %0d", w.month, month);
        mismatches++;
      end
      if (year !== w.year) begin
        $error("out_year: expected %0d, got %0d", w.year, year);
        mismatches++;
      end
      if (err !== w.err) begin
        $error("error: expected %0b, got %0b", w.err, err);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   recv_stall_pct;

  date_scoreboard sb = new();

  gdas_in_if  in_ch();
  gdas_out_if out_ch();

  gregorian_date_add_subtract_days uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock and reset
  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Known values on every input from time zero
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_LOAD;
    in_ch.load_day   = '0;
    in_ch.load_month = '0;
    in_ch.load_year  = '0;
    in_ch.day_count  = '0;
    out_ch.ready     = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
  end

  // Result side: random back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.out_day, out_ch.out_month, out_ch.out_year, out_ch.error);
  end

  // Drive one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(logic [OP_W-1:0] op, logic [DAY_W-1:0] ld,
                           logic [MON_W-1:0] lm, logic [YEAR_W-1:0] ly,
                           logic [CNT_W-1:0] cnt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.load_day   <= ld;
    in_ch.load_month <= lm;
    in_ch.load_year  <= ly;
    in_ch.day_count  <= cnt;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    sb.note_word(op, ld, lm, ly, cnt);
  endtask

  task automatic send_load(int unsigned d, int unsigned m, int unsigned y);
    send_word(OP_LOAD, DAY_W'(d), MON_W'(m), YEAR_W'(y), CNT_W'($urandom));
  endtask

  // Add or subtract; the load fields carry junk the block must ignore
  task automatic send_walk(logic [OP_W-1:0] op, int unsigned cnt);
    send_word(op, DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom), CNT_W'(cnt));
  endtask

  task automatic send_random();
    int unsigned r, sel, y, m, d, cnt;
    r = $urandom_range(99);
    if (r < 10) begin
      // raw noise on every field but the op code
      send_word(OP_LOAD, DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom),
                CNT_W'($urandom));
    end else if (r < 30) begin
      // calendar load, often at the ends of the year range
      sel = $urandom_range(9);
      if (sel == 0)      y = $urandom_range(3, 1);
      else if (sel == 1) y = $urandom_range(YEAR_MAX, YEAR_MAX - 2);
      else               y = $urandom_range(YEAR_MAX, 1);
      m = $urandom_range(MON_DEC, MON_JAN);
      d = ($urandom_range(7) == 0) ? sb.days_in(m, y) + 1 : $urandom_range(sb.days_in(m, y), 1);
      send_load(d, m, y);
    end else if (r < 33) begin
      send_word(OP_UNUSED, DAY_W'($urandom), MON_W'($urandom), YEAR_W'($urandom),
                CNT_W'($urandom));
    end else begin
      // mostly short walks, a few long ones
      sel = $urandom_range(99);
      if (sel < 80)      cnt = $urandom_range(400);
      else if (sel < 95) cnt = $urandom_range(5000);
      else               cnt = $urandom_range(65535);
      send_walk((r < 66) ? OP_ADD : OP_SUB, cnt);
    end
  endtask

  // Stimulus
  initial begin
    while (rst_n !== 1'b1) @(posedge clk);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase

      if (ph == 0) begin
        // zero counts straight out of reset
        send_walk(OP_ADD, 0);
        send_walk(OP_SUB, 0);
        // leap rule: by 400, by 100, by 4, plain year
        send_load(29, MON_FEB, 2000);
        send_load(29, MON_FEB, 1900);
        send_load(29, MON_FEB, 2024);
        send_load(29, MON_FEB, 2023);
        send_load(31, MON_APR, 2023);
        // out-of-range load fields
        send_load(0, MON_JAN, 2000);
        send_load(1, 0, 2000);
        send_load(31, 15, 2000);
        send_load(1, MON_JAN, 0);
        send_load(1, MON_JAN, YEAR_MAX + 1);
        send_load(31, MON_DEC, 16383);
        // top of the year range
        send_load(31, MON_DEC, YEAR_MAX);
        send_walk(OP_ADD, 1);
        send_walk(OP_SUB, 65535);
        // bottom of the year range
        send_load(1, MON_JAN, 1);
        send_walk(OP_SUB, 1);
        send_walk(OP_ADD, 65535);
        // century non-leap February and leap-year month ends
        send_load(28, MON_FEB, 2100);
        send_walk(OP_ADD, 1);
        send_load(31, MON_JAN, 2024);
        send_walk(OP_ADD, 30);
        send_word(OP_UNUSED, '1, '1, '1, '1);
      end

      repeat (WORDS_PER_PHASE) send_random();
      in_ch.valid <= 1'b0;
      // hold off until the block has answered everything
      while (sb.pending_dates.size() != 0) @(posedge clk);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_dates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
